// ===== rtl/core/websocket_frame_deframer_unit_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsdf assertion failed");
`define WSDF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wsdf assertion failed");
`else
`define WSDF_ASSERT(label, clk, rst_n, prop)
`define WSDF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/wsdf_pkg.sv =====
package wsdf_pkg;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CLOSED   = 2'd1;
    localparam logic [1:0] ST_TOOLARGE = 2'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One queued result, unmasking still to be done by the back end
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] key;
        logic       unmask;
        logic       has_byte;
        logic       last;
        logic [1:0] status;
    } t_cmd;

endpackage

// ===== rtl/core/wsdf_front.sv =====
`include "websocket_frame_deframer_unit_defines.svh"

module wsdf_front
    import wsdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALT    = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic [3:0]  r_ext, n_ext;
    logic [63:0] r_len, n_len;
    logic [1:0]  r_kidx, n_kidx;
    logic [31:0] r_max;
    logic [7:0]  r_key [4];

    logic [63:0] lk_len;
    logic        too_large;
    logic        lk_fire;
    logic        bp_fire;
    logic        key_wr;
    logic        is_end;

    // length candidate: 7-bit field in HDR1, shifted-in extended length otherwise
    assign lk_len    = (r_phase == PH_HDR1) ? {57'd0, i_byte[6:0]} : {r_len[55:0], i_byte};
    assign too_large = (|lk_len[63:32]) || (lk_len[31:0] > r_max);
    assign is_end    = (r_len == 64'd1);
    assign key_wr    = i_accept && (r_phase == PH_MASK);

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_ext    = r_ext;
        n_len    = r_len;
        n_kidx   = r_kidx;
        lk_fire  = 1'b0;
        bp_fire  = 1'b0;
        o_push   = 1'b0;
        o_cmd    = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_mask = i_byte[7];
                    if (i_byte[6:0] == LEN7_EXT16 || i_byte[6:0] == LEN7_EXT64) begin
                        n_ext   = (i_byte[6:0] == LEN7_EXT16) ? EXT_BYTES_16 : EXT_BYTES_64;
                        n_len   = '0;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_len   = lk_len;
                        lk_fire = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_len = lk_len;
                    n_ext = r_ext - 4'd1;
                    if (r_ext == 4'd1) begin
                        lk_fire = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_kidx = r_kidx + 2'd1;
                    if (r_kidx == 2'd3) begin
                        bp_fire = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_len  = r_len - 64'd1;
                    n_kidx = r_kidx + 2'd1;
                    if (is_end) begin
                        n_phase = PH_HDR0;
                    end
                    if (r_opcode == OP_TEXT) begin
                        o_push          = 1'b1;
                        o_cmd.raw       = i_byte;
                        o_cmd.key       = r_key[r_kidx];
                        o_cmd.unmask    = r_mask;
                        o_cmd.has_byte  = 1'b1;
                        o_cmd.last      = is_end;
                        o_cmd.status    = ST_OK;
                    end else if (r_opcode == OP_CLOSE && is_end) begin
                        n_phase      = PH_HALT;
                        o_push       = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.status = ST_CLOSED;
                    end
                end
                PH_HALT: begin
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end

        // full length known: limit check, then mask key or payload
        if (lk_fire) begin
            if (too_large) begin
                n_phase      = PH_HALT;
                o_push       = 1'b1;
                o_cmd.last   = 1'b1;
                o_cmd.status = ST_TOOLARGE;
            end else if (n_mask) begin
                n_kidx  = 2'd0;
                n_phase = PH_MASK;
            end else begin
                bp_fire = 1'b1;
            end
        end

        if (bp_fire) begin
            n_kidx = 2'd0;
            if (n_len == 64'd0) begin
                n_phase = PH_HDR0;
                if (r_opcode == OP_TEXT) begin
                    o_push       = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_OK;
                end else if (r_opcode == OP_CLOSE) begin
                    n_phase      = PH_HALT;
                    o_push       = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_CLOSED;
                end
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_ext    <= '0;
            r_len    <= '0;
            r_kidx   <= '0;
            r_max    <= MAX_LEN_RESET;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_ext    <= n_ext;
            r_len    <= n_len;
            r_kidx   <= n_kidx;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key[r_kidx] <= i_byte;
        end
    end

    `WSDF_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_phase == PH_HALT |=> r_phase == PH_HALT)
    `WSDF_ASSERT(a_payload_ends, i_clk, i_rst_n,
        i_accept && r_phase == PH_PAYLOAD && is_end |=> r_phase != PH_PAYLOAD)

endmodule

// ===== rtl/core/wsdf_queue.sv =====
`include "websocket_frame_deframer_unit_defines.svh"

module wsdf_queue
    import wsdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `WSDF_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `WSDF_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty)

endmodule

// ===== rtl/core/wsdf_back.sv =====
`include "websocket_frame_deframer_unit_defines.svh"

module wsdf_back
    import wsdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_has_byte,
    output logic       o_last,
    output logic [1:0] o_status
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_has;
    logic       r_last;
    logic [1:0] r_status;

    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= i_head.unmask ? (i_head.raw ^ i_head.key) : i_head.raw;
            r_has    <= i_head.has_byte;
            r_last   <= i_head.last;
            r_status <= i_head.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_data     = r_data;
    assign o_has_byte = r_has;
    assign o_last     = r_last;
    assign o_status   = r_status;

    `WSDF_ASSERT(a_marker_no_data, i_clk, i_rst_n, r_valid && !r_has |-> r_data == 8'd0)

endmodule

// ===== rtl/core/websocket_frame_deframer_unit.sv =====
// WebSocket frame deframer: takes the received stream one byte per item on s_axis
// and parses frame headers, extended lengths and mask keys, giving unmasked text
// payload bytes on m_axis (tuser[0] set, tlast on the frame's last byte; an empty
// text frame gives one tlast item with no byte). A close frame or a length above
// the max payload register gives one terminal status item, then the block absorbs
// input until reset. It takes one byte every clock while s_axis_tready is high;
// the header/length parser updates its registered state on each accepted byte,
// and results reach m_axis through the result queue and output register.
// s_axis_tready drops only when the four-entry result queue is full.
module websocket_frame_deframer_unit
    import wsdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [0] has_byte, [2:1] status
);

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd push_cmd;
    t_cmd head;
    logic has_byte;
    logic [1:0] status;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsdf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    wsdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wsdf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (head),
        .o_pop      (pop),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .o_has_byte (has_byte),
        .o_last     (m_axis_tlast),
        .o_status   (status)
    );

    assign m_axis_tuser = {status, has_byte};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wsdf_pkg::*;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_PING = 4'h9;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_HALT
    } t_parse_phase;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_enc;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic [1:0] status;
    } t_ws_out;

    typedef struct packed {
        logic [7:0] rx;
        logic       fixed;
        t_ws_out    want;
    } t_dir_row;

    localparam t_ws_out NO_OUT = '0;

    // Rows marked fixed carry their own expected result; others use the predictor.
    localparam t_dir_row DIRECTED [24] = '{
        // empty text frame
        '{8'h81, 1'b0, NO_OUT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        // unmasked text, FIN clear, extreme byte values
        '{8'h01, 1'b0, NO_OUT},
        '{8'h02, 1'b0, NO_OUT},
        '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, ST_OK}},
        '{8'hff, 1'b1, '{8'hff, 1'b1, 1'b1, ST_OK}},
        // masked text with 16-bit extended length
        '{8'h81, 1'b0, NO_OUT},
        '{8'hfe, 1'b0, NO_OUT},
        '{8'h00, 1'b0, NO_OUT},
        '{8'h01, 1'b0, NO_OUT},
        '{8'hff, 1'b0, NO_OUT},
        '{8'h00, 1'b0, NO_OUT},
        '{8'haa, 1'b0, NO_OUT},
        '{8'h55, 1'b0, NO_OUT},
        '{8'h0f, 1'b0, NO_OUT},
        // ping, payload dropped
        '{8'h89, 1'b0, NO_OUT},
        '{8'h01, 1'b0, NO_OUT},
        '{8'h77, 1'b0, NO_OUT},
        // masked empty text: end marker on the last key byte
        '{8'h81, 1'b0, NO_OUT},
        '{8'h80, 1'b0, NO_OUT},
        '{8'h12, 1'b0, NO_OUT},
        '{8'h34, 1'b0, NO_OUT},
        '{8'h56, 1'b0, NO_OUT},
        '{8'h78, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    websocket_frame_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    t_parse_phase p_phase = PH_HDR0;
    logic [31:0]  p_limit = MAX_LEN_RESET;
    logic [3:0]   p_opcode = '0;
    logic         p_masked = 1'b0;
    logic [3:0]   p_ext_left = '0;
    logic [63:0]  p_len = '0;
    logic [7:0]   p_key [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [1:0]   p_kidx = '0;

    t_ws_out results_due [$];
    int      errors = 0;
    bit      src_steady = 1'b0;
    bit      sink_steady = 1'b0;
    t_ws_out mon_want;
    t_ws_out mon_got;

    task automatic queue_expected(input t_ws_out r);
        results_due = {results_due, r};
    endtask

    function automatic bit payload_start(output t_ws_out r);
        r = '0;
        p_kidx = '0;
        if (p_len != 0) begin
            p_phase = PH_PAYLOAD;
            return 1'b0;
        end
        p_phase = PH_HDR0;
        r.last = 1'b1;
        if (p_opcode == OP_TEXT) begin
            r.status = ST_OK;
            return 1'b1;
        end
        if (p_opcode == OP_CLOSE) begin
            p_phase = PH_HALT;
            r.status = ST_CLOSED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Length check comes before any mask key byte.
    function automatic bit length_known(output t_ws_out r);
        r = '0;
        if (p_len > {32'd0, p_limit}) begin
            p_phase = PH_HALT;
            r.last = 1'b1;
            r.status = ST_TOOLARGE;
            return 1'b1;
        end
        if (p_masked) begin
            p_kidx = '0;
            p_phase = PH_MASK;
            return 1'b0;
        end
        return payload_start(r);
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output t_ws_out r);
        logic [6:0] len7;
        logic [7:0] v;
        r = '0;
        case (p_phase)
            PH_HDR0: begin
                p_opcode = b[3:0];
                p_phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                p_masked = b[7];
                len7 = b[6:0];
                p_len = '0;
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                    p_ext_left = (len7 == LEN7_EXT16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    p_phase = PH_EXTLEN;
                    return 1'b0;
                end
                p_len = {57'd0, len7};
                return length_known(r);
            end
            PH_EXTLEN: begin
                p_len = {p_len[55:0], b};
                p_ext_left = p_ext_left - 4'd1;
                if (p_ext_left == 0) return length_known(r);
                return 1'b0;
            end
            PH_MASK: begin
                p_key[p_kidx] = b;
                p_kidx = p_kidx + 2'd1;
                if (p_kidx == 0) return payload_start(r);
                return 1'b0;
            end
            PH_PAYLOAD: begin
                v = p_masked ? (b ^ p_key[p_kidx]) : b;
                p_kidx = p_kidx + 2'd1;
                p_len = p_len - 64'd1;
                if (p_len == 0) p_phase = PH_HDR0;
                if (p_opcode == OP_TEXT) begin
                    r.data = v;
                    r.has_byte = 1'b1;
                    r.last = (p_len == 0);
                    r.status = ST_OK;
                    return 1'b1;
                end
                if (p_opcode == OP_CLOSE && p_len == 0) begin
                    p_phase = PH_HALT;
                    r.last = 1'b1;
                    r.status = ST_CLOSED;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_ws_out r;
        put_byte(b);
        if (deframe_byte(b, r)) queue_expected(r);
    endtask

    task automatic send_frame(input logic [3:0] op, input logic [63:0] len, input bit masked,
                              input t_len_enc enc, input bit hdr_only);
        send_byte({4'($urandom_range(0, 15)), op});
        case (enc)
            LEN_SHORT: send_byte({masked, len[6:0]});
            LEN_EXT16: begin
                send_byte({masked, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (hdr_only) return;
        if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
        for (longint i = 0; i < longint'(len); i++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Config changes only once the parser has drained.
    task automatic write_limit(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        p_limit = v;
    endtask

    // Well-formed frames, never close, never over the limit.
    task automatic run_frames(input int goal);
        int          text_bytes;
        int          pick;
        logic [3:0]  op;
        logic [63:0] len;
        t_len_enc    enc;
        text_bytes = 0;
        while (text_bytes < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) op = OP_TEXT;
            else if (pick < 7) op = OP_PING;
            else if (pick == 7) op = OP_CONT;
            else begin
                op = 4'($urandom_range(2, 14));
                if (op >= OP_CLOSE) op = op + 4'd1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) len = 64'($urandom_range(126, 300));
            else if (pick == 1) len = (p_limit > 300) ? 64'd300 : {32'd0, p_limit};
            else len = 64'($urandom_range(0, 12));
            if (len > {32'd0, p_limit}) len = {32'd0, p_limit};
            if (len > 125) begin
                enc = ($urandom_range(0, 1) != 0) ? LEN_EXT64 : LEN_EXT16;
            end else begin
                pick = $urandom_range(0, 3);
                enc = (pick < 2) ? LEN_SHORT : (pick == 2) ? LEN_EXT16 : LEN_EXT64;
            end
            send_frame(op, len, 1'($urandom_range(0, 1)), enc, 1'b0);
            if (op == OP_TEXT) text_bytes += int'(len) + 2;
        end
    endtask

    initial begin
        int sink_wait;
        forever begin
            if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
            sink_wait = sink_steady ? 0 : int'($urandom_range(0, 3));
            if (sink_wait > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_wait) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]};
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: data %h has %b last %b status %0d",
                             mon_got.data, mon_got.has_byte, mon_got.last, mon_got.status);
            end else begin
                mon_want = results_due.pop_front();
                if (mon_got != mon_want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                                 mon_want.data, mon_want.has_byte, mon_want.last,
                                 mon_want.status, mon_got.data, mon_got.has_byte,
                                 mon_got.last, mon_got.status);
                end
            end
        end
    end

    initial begin
        t_ws_out     r;
        bit          hit;
        logic [63:0] len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            put_byte(DIRECTED[i].rx);
            hit = deframe_byte(DIRECTED[i].rx, r);
            if (DIRECTED[i].fixed) queue_expected(DIRECTED[i].want);
            else if (hit) queue_expected(r);
        end

        // zero limit: only empty frames, all length encodings
        write_limit(32'd0);
        run_frames(20);
        write_limit(32'($urandom_range(1, 24)));
        run_frames(120);
        write_limit(32'hffff_ffff);
        run_frames(100);

        // terminal frame, then bytes the halted block must swallow
        if ($urandom_range(0, 1) != 0) begin
            len = 64'($urandom_range(0, 5));
            send_frame(OP_CLOSE, len, 1'($urandom_range(0, 1)), LEN_SHORT, 1'b0);
        end else begin
            if ($urandom_range(0, 1) != 0) len = {32'd0, p_limit} + 64'd1;
            else len = {1'b1, 31'($urandom), 32'($urandom)};
            send_frame(4'($urandom_range(0, 15)), len, 1'($urandom_range(0, 1)),
                       LEN_EXT64, 1'b1);
        end
        repeat (12) send_byte(8'($urandom_range(0, 255)));
        s_axis_tvalid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
